// File: rtl/core/sfd_pkg.sv
// sfd_pkg: shared types and constants of the sensor frame decoder
// used by sfd_ctrl, sfd_datapath and sensor_frame_decoder_unit

package sfd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned VAL_W      = 17;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned TDATA_W    = 120;

  localparam logic [BYTE_W-1:0] END_BYTE_RST = 8'd13;
  localparam logic              REG_END_BYTE = 1'b0;

  localparam int unsigned DATA_START = 4;
  localparam logic [CNT_W-1:0] DATA_LAST = 4'd13;
  localparam int unsigned POS_TEMP   = 4;
  localparam int unsigned POS_PRESS  = 6;
  localparam int unsigned POS_WDIR   = 8;
  localparam int unsigned POS_HUM    = 9;
  localparam int unsigned POS_RAIN   = 10;
  localparam int unsigned POS_WIND   = 14;
  localparam int unsigned POS_LIGHT  = 16;
  localparam int unsigned POS_CSUM   = 18;

  localparam logic [VAL_W-1:0] TEMP_OFS  = 17'd1200;
  localparam logic [VAL_W-1:0] PRESS_OFS = 17'd8000;
  localparam logic [VAL_W-1:0] WIND_OFS  = 17'd4500;

  typedef struct packed {
    logic             wr_en;
    logic             sum_clr;
    logic             sum_en;
    logic [CNT_W-1:0] sum_idx;
    logic             load;
  } cmd_t;

  typedef struct packed {
    logic is_end;
    logic out_free;
  } status_t;

endpackage

// File: rtl/core/sfd_ctrl.sv
// sfd_ctrl: frame controller, byte intake, checksum sweep and result load
// depends on sfd_pkg

module sfd_ctrl
  import sfd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_LOAD
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.is_end) begin
          state_d = ST_SUM;
          cnt_d   = '0;
        end
      end
      ST_SUM: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DATA_LAST) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.wr_en   = (state_q == ST_IDLE) && in_valid_i && !status_i.is_end;
  assign cmd_o.sum_clr = (state_q == ST_IDLE) && in_valid_i && status_i.is_end;
  assign cmd_o.sum_en  = (state_q == ST_SUM);
  assign cmd_o.sum_idx = cnt_q;
  assign cmd_o.load    = (state_q == ST_LOAD) && status_i.out_free;

endmodule

// File: rtl/core/sfd_datapath.sv
// sfd_datapath: frame store, write position, checksum accumulator, field decode
// and result register; depends on sfd_pkg

module sfd_datapath
  import sfd_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  input  logic [BYTE_W-1:0]  end_byte_i,
  input  cmd_t               cmd_i,
  input  logic               out_ready_i,
  output status_t            status_o,
  output logic               out_valid_o,
  output logic [TDATA_W-1:0] out_data_o
);

  localparam int unsigned IDX_W = $clog2(BUFFER_DEPTH);
  localparam int unsigned POS_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [POS_W-1:0] POS_FULL = POS_W'(BUFFER_DEPTH);

  logic [BYTE_W-1:0]  store_q [BUFFER_DEPTH];
  logic [POS_W-1:0]   pos_q;
  logic               ovf_q;
  logic [SUM_W-1:0]   sum_q;
  logic               out_valid_q;
  logic [TDATA_W-1:0] out_data_q, out_data_d;
  logic [IDX_W-1:0]   sum_addr;
  logic [15:0]        w_temp, w_press, w_wind, w_light, w_csum;
  logic               csum_ok;

  assign sum_addr = IDX_W'(DATA_START) + IDX_W'(cmd_i.sum_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
        store_q[i] <= '0;
      end
      pos_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        if (pos_q != POS_FULL) begin
          store_q[pos_q[IDX_W-1:0]] <= rx_byte_i;
          pos_q <= pos_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end else if (cmd_i.load) begin
        pos_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
    end else if (cmd_i.sum_en) begin
      sum_q <= sum_q + SUM_W'(store_q[sum_addr]);
    end
  end

  assign w_temp  = {store_q[POS_TEMP],  store_q[POS_TEMP + 1]};
  assign w_press = {store_q[POS_PRESS], store_q[POS_PRESS + 1]};
  assign w_wind  = {store_q[POS_WIND],  store_q[POS_WIND + 1]};
  assign w_light = {store_q[POS_LIGHT], store_q[POS_LIGHT + 1]};
  assign w_csum  = {store_q[POS_CSUM],  store_q[POS_CSUM + 1]};
  assign csum_ok = ({4'b0, sum_q} == w_csum);

  always_comb begin
    out_data_d = {
      3'b000,
      w_light,
      {1'b0, w_wind} - WIND_OFS,
      store_q[POS_RAIN], store_q[POS_RAIN + 1], store_q[POS_RAIN + 2], store_q[POS_RAIN + 3],
      store_q[POS_HUM],
      store_q[POS_WDIR],
      {1'b0, w_press} - PRESS_OFS,
      {1'b0, w_temp} - TEMP_OFS,
      ovf_q,
      csum_ok
    };
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= out_data_d;
    end
  end

  assign status_o.is_end   = (rx_byte_i == end_byte_i);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule

// File: rtl/core/sensor_frame_decoder_unit.sv
// sensor_frame_decoder_unit: top level, register port, controller and datapath
// depends on sfd_pkg, sfd_ctrl, sfd_datapath
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   rx_byte
// m_axis    out  m_axis_tvalid / m_axis_tready   decoded frame result
// apb       in   psel / penable / pwrite         end_byte at address 0
//
// a non-end byte is stored (sets overflow if full); the next follows at once
// an end byte starts a checksum sweep over store bytes 4 to 17, one byte a cycle,
// then the result register is loaded
// the sweep and load hold s_axis_tready low; a stalled result register delays the load
// reset clears the store, position, overflow flag and sets end_byte to 13

module sensor_frame_decoder_unit
  import sfd_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // checksum_ok, overflowed, temperature_tenths, pressure_tenths, wind_direction,
  // humidity_percent, rain_count, wind_speed_hundredths, light_level, zero pad
  output logic [TDATA_W-1:0] m_axis_tdata,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [BYTE_W-1:0] end_byte_q;
  cmd_t              cmd;
  status_t           status;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_byte_q <= END_BYTE_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_END_BYTE)) begin
      end_byte_q <= pwdata[BYTE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_END_BYTE) ? {24'b0, end_byte_q} : '0;

  sfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  sfd_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (s_axis_tdata),
    .end_byte_i  (end_byte_q),
    .cmd_i       (cmd),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

  a_end_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && status.is_end) |=> !s_axis_tready)
    else $error("input taken during checksum sweep");

  a_result_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result loaded outside the sweep");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wr_en && (cmd.sum_en || cmd.load)))
    else $error("store write overlaps sweep or load");

endmodule
